// ----- hdl/dqsp_pkg.sv -----
// Shared types and constants for the DNS question section parser.
package dqsp_pkg;

  localparam logic [7:0] PTR_MARK  = 8'hC0;
  localparam logic [7:0] CAP_RESET = 8'd254;
  localparam logic [3:0] HDR_LEN   = 4'd12;
  localparam logic [3:0] HDR_QD_HI = 4'd4;
  localparam logic [3:0] HDR_QD_LO = 4'd5;
  localparam logic [1:0] TAIL_LAST = 2'd3;
  localparam logic [7:0] DOT_CHAR  = 8'h2E;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_TOO_LONG  = 3'd2;
  localparam logic [2:0] ST_MALFORMED = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER     = 3'd0,
    PH_NAME_START = 3'd1,
    PH_LABEL_LEN  = 3'd2,
    PH_LABEL_BODY = 3'd3,
    PH_POINTER2   = 3'd4,
    PH_TAIL       = 3'd5,
    PH_DONE       = 3'd6,
    PH_ERROR      = 3'd7
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  name_char;
    logic [2:0]  status;
    logic [15:0] question_count;
  } res_t;

endpackage

// ----- hdl/dqsp_in_stage.sv -----
// Input register stage: holds one accepted byte until the parser consumes it.
module dqsp_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_data_byte,
  input  logic          in_last_byte,
  input  logic          advance,
  output logic          item_vld,
  output dqsp_pkg::item_t item
);
  import dqsp_pkg::*;

  logic  vld_r, vld_nxt;
  item_t item_r;
  logic  take;

  assign in_stall = vld_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (advance) begin
      vld_nxt = 1'b0;
    end
    if (take) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.data_byte <= in_data_byte;
      item_r.last_byte <= in_last_byte;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// ----- hdl/dqsp_core.sv -----
// Parser state and the one-byte step: header, names, type/class, verdict.
module dqsp_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [7:0]      cfg_wr_data,
  input  logic            fire,
  input  dqsp_pkg::item_t item,
  output logic            res_vld,
  output dqsp_pkg::res_t  res
);
  import dqsp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hdr_idx_r, hdr_idx_nxt;
  logic [15:0] q_total_r, q_total_nxt;
  logic [15:0] q_done_r, q_done_nxt;
  logic [7:0]  label_left_r, label_left_nxt;
  logic [7:0]  name_len_r, name_len_nxt;
  logic [1:0]  tail_r, tail_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [7:0]  cap_r;

  logic        emit;
  logic [7:0]  ch;
  logic        first_q;
  logic        over_cap;
  logic [7:0]  b;
  logic        last;
  logic [2:0]  pend_status;
  logic [15:0] q_done_inc;

  assign b          = item.data_byte;
  assign last       = item.last_byte;
  assign first_q    = (q_done_r == 16'd0);
  assign over_cap   = (name_len_r >= cap_r);
  assign q_done_inc = q_done_r + 16'd1;

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    hdr_idx_nxt    = hdr_idx_r;
    q_total_nxt    = q_total_r;
    q_done_nxt     = q_done_r;
    label_left_nxt = label_left_r;
    name_len_nxt   = name_len_r;
    tail_nxt       = tail_r;
    err_nxt        = err_r;
    emit           = 1'b0;
    ch             = 8'd0;
    unique case (phase_r) inside
      PH_HEADER: begin
        if (last) begin
          phase_nxt = PH_ERROR;
          err_nxt   = (err_r == ST_OK) ? ST_SHORT : err_r;
        end else begin
          if (hdr_idx_r == HDR_QD_HI) begin
            q_total_nxt = {b, q_total_r[7:0]};
          end else if (hdr_idx_r == HDR_QD_LO) begin
            q_total_nxt = {q_total_r[15:8], b};
          end
          hdr_idx_nxt = hdr_idx_r + 4'd1;
          if (hdr_idx_nxt == HDR_LEN) begin
            phase_nxt = (q_total_nxt == 16'd0) ? PH_DONE : PH_NAME_START;
          end
        end
      end
      PH_NAME_START: begin
        if ((b & PTR_MARK) == PTR_MARK) begin
          phase_nxt = PH_POINTER2;
        end else if (b == 8'd0) begin
          phase_nxt = PH_ERROR;
          err_nxt   = (err_r == ST_OK) ? ST_MALFORMED : err_r;
        end else begin
          label_left_nxt = b;
          phase_nxt      = PH_LABEL_BODY;
        end
      end
      PH_POINTER2: begin
        if (last) begin
          phase_nxt = PH_ERROR;
          err_nxt   = (err_r == ST_OK) ? ST_MALFORMED : err_r;
        end else begin
          tail_nxt  = 2'd0;
          phase_nxt = PH_TAIL;
        end
      end
      PH_LABEL_LEN: begin
        if (b == 8'd0) begin
          if (first_q && over_cap) begin
            phase_nxt = PH_ERROR;
            err_nxt   = (err_r == ST_OK) ? ST_TOO_LONG : err_r;
          end else begin
            tail_nxt  = 2'd0;
            phase_nxt = PH_TAIL;
          end
        end else if (first_q && name_len_r != 8'd0 && over_cap) begin
          phase_nxt = PH_ERROR;
          err_nxt   = (err_r == ST_OK) ? ST_TOO_LONG : err_r;
        end else begin
          if (first_q && name_len_r != 8'd0) begin
            emit         = 1'b1;
            ch           = DOT_CHAR;
            name_len_nxt = name_len_r + 8'd1;
          end
          label_left_nxt = b;
          phase_nxt      = PH_LABEL_BODY;
        end
      end
      PH_LABEL_BODY: begin
        if (first_q && over_cap) begin
          phase_nxt = PH_ERROR;
          err_nxt   = (err_r == ST_OK) ? ST_TOO_LONG : err_r;
        end else begin
          if (first_q) begin
            emit         = 1'b1;
            ch           = b;
            name_len_nxt = name_len_r + 8'd1;
          end
          label_left_nxt = label_left_r - 8'd1;
          if (label_left_r == 8'd1) begin
            phase_nxt = PH_LABEL_LEN;
          end
        end
      end
      PH_TAIL: begin
        if (tail_r >= TAIL_LAST) begin
          tail_nxt   = 2'd0;
          q_done_nxt = q_done_inc;
          phase_nxt  = (q_done_inc == q_total_r) ? PH_DONE : PH_NAME_START;
        end else begin
          tail_nxt = tail_r + 2'd1;
        end
      end
      PH_DONE, PH_ERROR: ;
    endcase
  end

  // outputs
  always_comb begin
    unique case (phase_nxt) inside
      PH_DONE:   pend_status = ST_OK;
      PH_HEADER: pend_status = ST_SHORT;
      PH_TAIL:   pend_status = ST_TRUNC;
      default:   pend_status = ST_MALFORMED;
    endcase
    res_vld            = last || emit;
    res.question_count = q_total_nxt;
    if (last) begin
      res.kind      = KIND_VERDICT;
      res.name_char = 8'd0;
      res.status    = (err_nxt != ST_OK) ? err_nxt : pend_status;
    end else begin
      res.kind      = KIND_CHAR;
      res.name_char = ch;
      res.status    = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      hdr_idx_r    <= 4'd0;
      q_total_r    <= 16'd0;
      q_done_r     <= 16'd0;
      label_left_r <= 8'd0;
      name_len_r   <= 8'd0;
      tail_r       <= 2'd0;
      err_r        <= ST_OK;
    end else if (fire) begin
      if (last) begin
        phase_r      <= PH_HEADER;
        hdr_idx_r    <= 4'd0;
        q_total_r    <= 16'd0;
        q_done_r     <= 16'd0;
        label_left_r <= 8'd0;
        name_len_r   <= 8'd0;
        tail_r       <= 2'd0;
        err_r        <= ST_OK;
      end else begin
        phase_r      <= phase_nxt;
        hdr_idx_r    <= hdr_idx_nxt;
        q_total_r    <= q_total_nxt;
        q_done_r     <= q_done_nxt;
        label_left_r <= label_left_nxt;
        name_len_r   <= name_len_nxt;
        tail_r       <= tail_nxt;
        err_r        <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

endmodule

// ----- hdl/dqsp_out_stage.sv -----
// Result register: holds one result until the receiver takes it.
module dqsp_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  logic           res_vld,
  input  dqsp_pkg::res_t res,
  output logic           advance,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_kind,
  output logic [7:0]     out_name_char,
  output logic [2:0]     out_status,
  output logic [15:0]    out_question_count
);
  import dqsp_pkg::*;

  logic vld_r;
  res_t res_r;

  assign advance = !vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= fire && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid          = vld_r;
  assign out_kind           = res_r.kind;
  assign out_name_char      = res_r.name_char;
  assign out_status         = res_r.status;
  assign out_question_count = res_r.question_count;

endmodule

// ----- hdl/dns_question_section_parser.sv -----
// Top level of the DNS question section parser.
//
// Bytes of a DNS message arrive on in_* one per transfer, in_last_byte
// marking the final byte. The header gives the question count; each
// question name is walked and the first name's characters, with dots
// between labels, come out on out_* as name-character results
// (out_kind 0). The final byte gives a verdict result (out_kind 1) with
// out_status and out_question_count, after which the next byte starts
// a new message. cfg_wr_en/cfg_wr_data set the name capacity (254 after
// reset). The user writes them only between messages; the block does
// not enforce this. One byte is accepted every cycle while in_stall is
// low. A byte is held in the input register; its result, if any, is
// loaded into the result register when the parser takes the byte, and
// transfers from there when out_stall is low.
// While out_stall holds a result, the result register holds still and
// in_stall rises as soon as the input register is also occupied.
// Synchronous reset clears the valid flags of both registers and the
// parser state and sets the capacity back to 254.
module dns_question_section_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_name_char,
  output logic [2:0]  out_status,
  output logic [15:0] out_question_count,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import dqsp_pkg::*;

  logic  advance;
  logic  item_vld;
  item_t item;
  logic  fire;
  logic  res_vld;
  res_t  res;

  assign fire = item_vld && advance;

  dqsp_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .advance      (advance),
    .item_vld     (item_vld),
    .item         (item)
  );

  dqsp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .item        (item),
    .res_vld     (res_vld),
    .res         (res)
  );

  dqsp_out_stage u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .fire               (fire),
    .res_vld            (res_vld),
    .res                (res),
    .advance            (advance),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_name_char      (out_name_char),
    .out_status         (out_status),
    .out_question_count (out_question_count)
  );

endmodule

// ----- hdl/dqsp_chk.sv -----
// Port-level checks for the DNS question section parser, bound to the top level.
module dqsp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_kind,
  input logic [7:0]  out_name_char,
  input logic [2:0]  out_status,
  input logic [15:0] out_question_count
);
  import dqsp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_name_char)
      && $stable(out_status) && $stable(out_question_count))
    else $error("stalled result changed");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_VERDICT |-> out_name_char == 8'd0
      && (out_status == ST_OK || out_status == ST_SHORT || out_status == ST_TOO_LONG
      || out_status == ST_MALFORMED || out_status == ST_TRUNC))
    else $error("bad verdict fields");

  a_char_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_CHAR |-> out_status == ST_OK)
    else $error("name character carries a status");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_byte && !out_valid ##1 !out_valid |=> out_valid)
    else $error("verdict missing after last byte transfer");

endmodule

bind dns_question_section_parser dqsp_chk u_dqsp_chk (.*);

// ----- test/dns_question_section_parser_tb.sv -----
// Self-checking testbench for dns_question_section_parser: directed messages, then random traffic.
module dns_question_section_parser_tb;
  import dqsp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int N_DIR = 15;
  localparam int PHASE_BYTES = 120;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [7:0]  out_name_char;
  logic [2:0]  out_status;
  logic [15:0] out_question_count;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;

  dns_question_section_parser u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_name_char      (out_name_char),
    .out_status         (out_status),
    .out_question_count (out_question_count),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  // directed message: header bytes (count fields from qd, rest pad), then body bytes
  typedef struct packed {
    logic [3:0]   hdr_n;
    logic [15:0]  qd;
    logic [7:0]   pad;
    logic [4:0]   n;
    logic [127:0] body;
    logic [7:0]   cap;
    logic [2:0]   st;
    logic [15:0]  qc;
  } dir_msg_t;

  dir_msg_t dir_tbl [N_DIR] = '{
    '{4'd1,  16'h0000, 8'hFF, 5'd0,  128'h0, 8'd254, ST_SHORT, 16'h0000},
    '{4'd12, 16'hFFFF, 8'h00, 5'd0,  128'h0, 8'd254, ST_SHORT, 16'hFFFF},
    '{4'd12, 16'h0000, 8'hFF, 5'd3,  128'hFF_C0_00, 8'd254, ST_OK, 16'h0000},
    '{4'd12, 16'h0001, 8'h00, 5'd12, 128'h03_616263_02_7879_00_0001_0001, 8'd254, ST_OK,
      16'h0001},
    '{4'd12, 16'h0001, 8'h5A, 5'd5,  128'h00_0001_0001, 8'd254, ST_MALFORMED, 16'h0001},
    '{4'd12, 16'h0002, 8'hA5, 5'd13, 128'h01_71_00_0001_0001_FF3F_0001_0001, 8'd254, ST_OK,
      16'h0002},
    '{4'd12, 16'h0001, 8'h00, 5'd2,  128'hC0_0C, 8'd254, ST_MALFORMED, 16'h0001},
    '{4'd12, 16'h0100, 8'h00, 5'd1,  128'hC0, 8'd254, ST_MALFORMED, 16'h0100},
    '{4'd12, 16'h0001, 8'h00, 5'd3,  128'h03_61_62, 8'd254, ST_MALFORMED, 16'h0001},
    '{4'd12, 16'h0001, 8'h00, 5'd5,  128'h01_61_00_00_01, 8'd254, ST_TRUNC, 16'h0001},
    '{4'd12, 16'h0001, 8'h00, 5'd5,  128'h01_61_C0_78_79, 8'd254, ST_MALFORMED, 16'h0001},
    '{4'd12, 16'h0001, 8'h00, 5'd7,  128'h01_61_00_0001_0001, 8'd0, ST_TOO_LONG, 16'h0001},
    '{4'd12, 16'h0001, 8'h00, 5'd9,  128'h01_61_01_62_00_0001_0001, 8'd1, ST_TOO_LONG,
      16'h0001},
    '{4'd12, 16'h0001, 8'h00, 5'd8,  128'h02_61_62_00_0001_0001, 8'd2, ST_TOO_LONG, 16'h0001},
    '{4'd12, 16'h0001, 8'hFF, 5'd9,  128'h03_616263_00_0001_0001, 8'd255, ST_OK, 16'h0001}
  };

  // parser state mirror
  phase_t      p_phase;
  logic [3:0]  p_hdr_idx;
  logic [15:0] p_qd_total;
  logic [15:0] p_qd_done;
  logic [7:0]  p_lbl_left;
  logic [7:0]  p_name_len;
  logic [1:0]  p_tail;
  logic [2:0]  p_err;
  logic [7:0]  p_cap;

  res_t        char_verdict_q [$];
  logic [7:0]  msg_bytes [$];
  int          cycle_cnt = 0;
  int          err_cnt = 0;
  int          burst_left = 0;
  int          stall_mode = 0;
  int          bytes_sent = 0;
  int          msgs_sent = 0;
  int          chars_checked = 0;
  int          verdicts_checked = 0;
  int          verdict_hits [8];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 64 == 0) stall_mode <= $urandom_range(3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(3) == 0);
      2: out_stall <= ($urandom_range(3) != 0);
      default: out_stall <= (cycle_cnt % 5) < 2;
    endcase
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("dns_question_section_parser regression: fail");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_cnt < 40)
      $display("MISMATCH cycle %0d: %s got 0x%0h want 0x%0h", cycle_cnt, what, got, want);
    err_cnt++;
  endtask

  function automatic void clear_parse_state();
    p_phase    = PH_HEADER;
    p_hdr_idx  = '0;
    p_qd_total = '0;
    p_qd_done  = '0;
    p_lbl_left = '0;
    p_name_len = '0;
    p_tail     = '0;
    p_err      = ST_OK;
  endfunction

  function automatic void latch_error(input logic [2:0] code);
    if (p_err == ST_OK) p_err = code;
    p_phase = PH_ERROR;
  endfunction

  // advance the parser mirror by one byte; returns 1 when the byte yields an output
  function automatic bit parse_byte(input logic [7:0] b, input logic lst, output res_t r);
    bit         first_q;
    bit         emit;
    logic [7:0] ch;
    logic [2:0] st;
    first_q = (p_qd_done == 16'd0);
    emit = 1'b0;
    ch = 8'h00;
    r = '0;
    case (p_phase)
      PH_HEADER: begin
        if (lst) begin
          latch_error(ST_SHORT);
        end else begin
          if (p_hdr_idx == HDR_QD_HI) p_qd_total[15:8] = b;
          else if (p_hdr_idx == HDR_QD_LO) p_qd_total[7:0] = b;
          p_hdr_idx = p_hdr_idx + 4'd1;
          if (p_hdr_idx == HDR_LEN) p_phase = (p_qd_total == 16'd0) ? PH_DONE : PH_NAME_START;
        end
      end
      PH_NAME_START: begin
        if ((b & PTR_MARK) == PTR_MARK) begin
          p_phase = PH_POINTER2;
        end else if (b == 8'd0) begin
          latch_error(ST_MALFORMED);
        end else begin
          p_lbl_left = b;
          p_phase = PH_LABEL_BODY;
        end
      end
      PH_POINTER2: begin
        if (lst) begin
          latch_error(ST_MALFORMED);
        end else begin
          p_tail = '0;
          p_phase = PH_TAIL;
        end
      end
      PH_LABEL_LEN: begin
        if (b == 8'd0) begin
          if (first_q && p_name_len >= p_cap) begin
            latch_error(ST_TOO_LONG);
          end else begin
            p_tail = '0;
            p_phase = PH_TAIL;
          end
        end else if (first_q && p_name_len > 8'd0 && p_name_len >= p_cap) begin
          latch_error(ST_TOO_LONG);
        end else begin
          if (first_q && p_name_len > 8'd0) begin
            emit = 1'b1;
            ch = DOT_CHAR;
            p_name_len++;
          end
          p_lbl_left = b;
          p_phase = PH_LABEL_BODY;
        end
      end
      PH_LABEL_BODY: begin
        if (first_q && p_name_len >= p_cap) begin
          latch_error(ST_TOO_LONG);
        end else begin
          if (first_q) begin
            emit = 1'b1;
            ch = b;
            p_name_len++;
          end
          p_lbl_left--;
          if (p_lbl_left == 8'd0) p_phase = PH_LABEL_LEN;
        end
      end
      PH_TAIL: begin
        if (p_tail >= TAIL_LAST) begin
          p_tail = '0;
          p_qd_done++;
          p_phase = (p_qd_done == p_qd_total) ? PH_DONE : PH_NAME_START;
        end else begin
          p_tail++;
        end
      end
      default: ;
    endcase
    if (lst) begin
      if (p_err != ST_OK) begin
        st = p_err;
      end else begin
        case (p_phase)
          PH_DONE:   st = ST_OK;
          PH_HEADER: st = ST_SHORT;
          PH_TAIL:   st = ST_TRUNC;
          default:   st = ST_MALFORMED;
        endcase
      end
      r.kind = KIND_VERDICT;
      r.name_char = 8'h00;
      r.status = st;
      r.question_count = p_qd_total;
      clear_parse_state();
      return 1'b1;
    end
    r.kind = KIND_CHAR;
    r.name_char = ch;
    r.status = ST_OK;
    r.question_count = p_qd_total;
    return emit;
  endfunction

  // one byte transfer; a typed verdict replaces the mirror's status and count
  task automatic send_byte(input logic [7:0] b, input logic lst, input bit typed,
                           input logic [2:0] st, input logic [15:0] qc);
    res_t r;
    bit   got;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      burst_left = $urandom_range(40, 1);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= lst;
    do @(posedge clk); while (in_stall);
    burst_left--;
    bytes_sent++;
    got = parse_byte(b, lst, r);
    if (got) begin
      if (lst && typed) begin
        r.status = st;
        r.question_count = qc;
      end
      char_verdict_q.push_back(r);
    end
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    do @(posedge clk); while (char_verdict_q.size() != 0);
  endtask

  task automatic write_capacity(input logic [7:0] v);
    drain_outputs();
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    p_cap = v;
  endtask

  // mostly well-formed messages with random content, some noise and damage
  task automatic build_message();
    logic [15:0] qd;
    int          nq;
    int          nlab;
    int          len;
    int          k;
    int          q;
    int          l;
    msg_bytes.delete();
    if ($urandom_range(9) == 0) begin
      len = $urandom_range(20, 1);
      repeat (len) msg_bytes.push_back(8'($urandom));
    end else begin
      case ($urandom_range(7))
        0: qd = 16'h0000;
        1: qd = 16'($urandom_range(65535));
        default: qd = 16'($urandom_range(3, 1));
      endcase
      for (k = 0; k < 12; k++) begin
        if (k == HDR_QD_HI) msg_bytes.push_back(qd[15:8]);
        else if (k == HDR_QD_LO) msg_bytes.push_back(qd[7:0]);
        else msg_bytes.push_back(8'($urandom));
      end
      nq = (qd > 16'd3) ? 3 : int'(qd);
      for (q = 0; q < nq; q++) begin
        if ($urandom_range(5) == 0) begin
          msg_bytes.push_back(PTR_MARK | 8'($urandom_range(63)));
          msg_bytes.push_back(8'($urandom));
        end else begin
          nlab = $urandom_range(4, 1);
          for (l = 0; l < nlab; l++) begin
            if (l > 0 && $urandom_range(39) == 0) len = $urandom_range(255, 192);
            else if ($urandom_range(7) == 0) len = $urandom_range(63, 1);
            else len = $urandom_range(8, 1);
            msg_bytes.push_back(8'(len));
            repeat (len) msg_bytes.push_back(8'($urandom));
          end
          msg_bytes.push_back(8'h00);
        end
        repeat (4) msg_bytes.push_back(8'($urandom));
      end
      repeat ($urandom_range(2)) msg_bytes.push_back(8'($urandom));
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(2))
          0: begin
            len = $urandom_range(msg_bytes.size(), 1);
            msg_bytes = msg_bytes[0:len-1];
          end
          1: msg_bytes[$urandom_range(msg_bytes.size() - 1)] = 8'($urandom);
          default: msg_bytes.insert($urandom_range(msg_bytes.size() - 1, 12), 8'h00);
        endcase
      end
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (char_verdict_q.size() == 0) begin
        report_mismatch("unexpected transfer, kind", out_kind, 0);
      end else begin
        want = char_verdict_q.pop_front();
        if (out_kind !== want.kind) report_mismatch("kind", out_kind, want.kind);
        if (out_name_char !== want.name_char)
          report_mismatch("name_char", out_name_char, want.name_char);
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_question_count !== want.question_count)
          report_mismatch("question_count", out_question_count, want.question_count);
        if (want.kind == KIND_VERDICT) begin
          verdicts_checked++;
          verdict_hits[want.status]++;
        end else begin
          chars_checked++;
        end
      end
    end
  end

  initial begin
    dir_msg_t    row;
    logic [7:0]  b;
    logic [7:0]  cap_v;
    int          i;
    int          k;
    int          total;
    int          phase_bytes;
    int          tail_wait;
    for (i = 0; i < 8; i++) verdict_hits[i] = 0;
    clear_parse_state();
    p_cap = CAP_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIR; i++) begin
      row = dir_tbl[i];
      if (row.cap != p_cap) write_capacity(row.cap);
      total = row.hdr_n + row.n;
      for (k = 0; k < total; k++) begin
        if (k >= row.hdr_n) b = row.body[8 * (row.n - 1 - (k - row.hdr_n)) +: 8];
        else if (k == HDR_QD_HI) b = row.qd[15:8];
        else if (k == HDR_QD_LO) b = row.qd[7:0];
        else b = row.pad;
        send_byte(b, k == total - 1, 1'b1, row.st, row.qc);
      end
      msgs_sent++;
    end

    for (i = 0; i < 6; i++) begin
      case (i)
        0: cap_v = 8'd255;
        1: cap_v = 8'd0;
        2: cap_v = 8'd1;
        3: cap_v = 8'($urandom_range(12, 3));
        4: cap_v = CAP_RESET;
        default: cap_v = 8'($urandom_range(40, 2));
      endcase
      write_capacity(cap_v);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        build_message();
        for (k = 0; k < msg_bytes.size(); k++)
          send_byte(msg_bytes[k], k == msg_bytes.size() - 1, 1'b0, ST_OK, 16'h0000);
        phase_bytes += msg_bytes.size();
        msgs_sent++;
        if ($urandom_range(7) == 0) drain_outputs();
      end
    end

    in_valid <= 1'b0;
    tail_wait = 0;
    do begin
      @(posedge clk);
      tail_wait++;
    end while (char_verdict_q.size() != 0 && tail_wait < 5000);
    repeat (8) @(posedge clk);
    if (char_verdict_q.size() != 0)
      report_mismatch("results never delivered, count", 0, char_verdict_q.size());

    $display("covered %0d messages / %0d bytes: %0d name chars, %0d verdicts", msgs_sent,
             bytes_sent, chars_checked, verdicts_checked);
    $display("verdicts ok %0d short %0d too-long %0d malformed %0d truncated %0d",
             verdict_hits[ST_OK], verdict_hits[ST_SHORT], verdict_hits[ST_TOO_LONG],
             verdict_hits[ST_MALFORMED], verdict_hits[ST_TRUNC]);
    if (err_cnt == 0) begin
      $display("dns_question_section_parser regression: pass");
    end else begin
      $display("dns_question_section_parser regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/dqsp_pkg.sv
hdl/dqsp_in_stage.sv
hdl/dqsp_core.sv
hdl/dqsp_out_stage.sv
hdl/dns_question_section_parser.sv
hdl/dqsp_chk.sv
test/dns_question_section_parser_tb.sv
